[rtl/pct_pkg.sv]
// ----------------------------------------------------------------------------
// pct_pkg
// Shared types and constants for the prescaled compare timer: opcodes,
// register offsets, control and status bit masks, and the item structs.
// ----------------------------------------------------------------------------
package pct_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } pct_op_e;

  localparam logic [11:0] OffCtrl     = 12'h000;
  localparam logic [11:0] OffPrescale = 12'h004;
  localparam logic [11:0] OffStatus   = 12'h008;
  localparam logic [11:0] OffIrqEn    = 12'h00C;
  localparam logic [11:0] OffCompare  = 12'h010;
  localparam logic [11:0] OffCount    = 12'h024;

  localparam logic [31:0] CtrlSoftReset = 32'h0000_8000;
  localparam int unsigned CtrlEnableBit = 0;
  localparam int unsigned FlagOvfBit    = 0;
  localparam int unsigned IrqEnOvfBit   = 0;
  localparam int unsigned DivWidth      = 12;

  // One bus read, bus write or source clock tick.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [11:0] reg_offset;
    logic [31:0] write_value;
  } pct_item_t;

  // What one item produces.
  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_level;
  } pct_result_t;

endpackage

[rtl/pct_core.sv]
// ----------------------------------------------------------------------------
// pct_core
// Register bank and counter state of the timer. Applies one item per cycle
// when fire_i is high and presents the item's result combinationally.
// ----------------------------------------------------------------------------
module pct_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  pct_pkg::pct_item_t   item_i,
  output pct_pkg::pct_result_t result_o
);

  logic [31:0] control_q, control_d;
  logic [31:0] prescale_q, prescale_d;
  logic [31:0] status_q, status_d;
  logic [31:0] irq_en_q, irq_en_d;
  logic [31:0] compare_q, compare_d;
  logic [31:0] count_q, count_d;
  logic [pct_pkg::DivWidth-1:0] pre_cnt_q, pre_cnt_d;

  logic        enabled;
  logic [31:0] rdata;

  assign enabled = control_q[pct_pkg::CtrlEnableBit];

  always_comb begin
    control_d  = control_q;
    prescale_d = prescale_q;
    status_d   = status_q;
    irq_en_d   = irq_en_q;
    compare_d  = compare_q;
    count_d    = count_q;
    pre_cnt_d  = pre_cnt_q;
    rdata      = 32'd0;

    unique case (item_i.opcode)
      pct_pkg::OP_READ: begin
        unique case (item_i.reg_offset)
          pct_pkg::OffCtrl:     rdata = control_q;
          pct_pkg::OffPrescale: rdata = prescale_q;
          pct_pkg::OffStatus:   rdata = status_q;
          pct_pkg::OffIrqEn:    rdata = irq_en_q;
          pct_pkg::OffCompare:  rdata = compare_q;
          pct_pkg::OffCount:    rdata = count_q;
          default:              rdata = 32'd0;
        endcase
      end
      pct_pkg::OP_WRITE: begin
        unique case (item_i.reg_offset)
          pct_pkg::OffCtrl: begin
            if ((item_i.write_value & pct_pkg::CtrlSoftReset) != 32'd0) begin
              // Software reset clears the bank; no restart follows.
              prescale_d = 32'd0;
              status_d   = 32'd0;
              irq_en_d   = 32'd0;
              compare_d  = 32'd0;
              count_d    = 32'd0;
              pre_cnt_d  = '0;
              control_d  = item_i.write_value & ~pct_pkg::CtrlSoftReset;
            end else begin
              control_d = item_i.write_value;
              if (!enabled && item_i.write_value[pct_pkg::CtrlEnableBit]) begin
                count_d   = 32'd0;
                pre_cnt_d = '0;
              end
            end
          end
          pct_pkg::OffPrescale: begin
            prescale_d = item_i.write_value;
            if (enabled) begin
              count_d   = 32'd0;
              pre_cnt_d = '0;
            end
          end
          pct_pkg::OffStatus: status_d = status_q & ~item_i.write_value;
          pct_pkg::OffIrqEn:  irq_en_d = item_i.write_value;
          pct_pkg::OffCompare: begin
            compare_d = item_i.write_value;
            if (enabled) begin
              count_d   = 32'd0;
              pre_cnt_d = '0;
            end
          end
          default: ;
        endcase
      end
      pct_pkg::OP_TICK: begin
        if (enabled && compare_q != 32'd0) begin
          if (pre_cnt_q >= prescale_q[pct_pkg::DivWidth-1:0]) begin
            pre_cnt_d = '0;
            if (count_q >= compare_q) begin
              count_d = 32'd0;
              status_d[pct_pkg::FlagOvfBit] = 1'b1;
            end else begin
              count_d = count_q + 32'd1;
            end
          end else begin
            pre_cnt_d = pre_cnt_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign result_o.read_data = rdata;
  assign result_o.irq_level = status_d[pct_pkg::FlagOvfBit] & irq_en_d[pct_pkg::IrqEnOvfBit];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      control_q  <= 32'd0;
      prescale_q <= 32'd0;
      status_q   <= 32'd0;
      irq_en_q   <= 32'd0;
      compare_q  <= 32'd0;
      count_q    <= 32'd0;
      pre_cnt_q  <= '0;
    end else if (fire_i) begin
      control_q  <= control_d;
      prescale_q <= prescale_d;
      status_q   <= status_d;
      irq_en_q   <= irq_en_d;
      compare_q  <= compare_d;
      count_q    <= count_d;
      pre_cnt_q  <= pre_cnt_d;
    end
  end

endmodule

[rtl/prescaled_compare_timer.sv]
// ----------------------------------------------------------------------------
// prescaled_compare_timer
// General purpose timer with output compare in restart mode, driven by a
// stream of bus reads, bus writes and source clock ticks.
// ----------------------------------------------------------------------------
// Every input beat is one bus read, one bus write or one tick of the timer's
// source clock, and each beat yields exactly one result beat carrying the read
// data (zero for writes, ticks and unmapped offsets) and the interrupt level
// after that beat. The block takes one beat per cycle while in_stall_o is low: a
// beat is captured in an input register, processed by the register bank in
// pct_core once the output register is free, and its result lands in an
// output register. The input register doubles as a skid stage: while a
// finished result waits on out_stall_i, one more beat is still taken, and
// only then does in_stall_o rise. Throughput is one beat per cycle whenever
// the consumer keeps up; the register bank's combinational path (a 32-bit
// compare and increment for the count) sets that figure.
// ----------------------------------------------------------------------------
module prescaled_compare_timer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [11:0] reg_offset_i,
  input  logic [31:0] write_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_data_o,
  output logic        irq_level_o
);

  // Input register stage.
  logic                 in_valid_q;
  pct_pkg::pct_item_t   item_q;

  // Output register stage.
  logic                 out_valid_q;
  pct_pkg::pct_result_t result_q;
  pct_pkg::pct_result_t result_d;

  logic advance;  // the held input beat moves into the output register
  logic in_fire;  // a new input beat is captured

  // The output register is free when empty or being drained this cycle.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.opcode      <= opcode_i;
      item_q.reg_offset  <= reg_offset_i;
      item_q.write_value <= write_value_i;
    end
  end

  // The register bank commits the held beat's effects exactly when it moves on.
  pct_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (item_q),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = result_q.read_data;
  assign irq_level_o = result_q.irq_level;

endmodule

[tb/prescaled_compare_timer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// prescaled_compare_timer_tb
// Self-checking bench for the prescaled compare timer. Bus reads, bus writes
// and source clock ticks are sent as input beats. A behavioral model of the
// register bank, prescaler and counter predicts each result beat. A monitor
// compares every result beat with the oldest prediction. The random traffic
// runs under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module prescaled_compare_timer_tb;

  // Opcode 3 is not decoded by the block; it must behave as a no-op.
  localparam logic [1:0] OpUnused = 2'd3;
  // Cycles without any accepted beat, on either side, before the run aborts.
  localparam int unsigned HangLimit = 2000;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned BeatsPerPhase = 388;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  opcode_i;
  logic [11:0] reg_offset_i;
  logic [31:0] write_value_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] read_data_o;
  logic        irq_level_o;

  prescaled_compare_timer u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .reg_offset_i (reg_offset_i),
    .write_value_i(write_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o),
    .irq_level_o  (irq_level_o)
  );

  // 20 ns clock, low for the first half period.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // --------------------------------------------------------------------------
  // Timer model. These mirror the block's registers and are updated once per
  // accepted input beat, in acceptance order.
  // --------------------------------------------------------------------------
  logic [31:0]                  tmr_ctrl;
  logic [31:0]                  tmr_prescale;
  logic [31:0]                  tmr_status;
  logic [31:0]                  tmr_irq_en;
  logic [31:0]                  tmr_compare;
  logic [31:0]                  tmr_count;
  logic [pct_pkg::DivWidth-1:0] tmr_div_cnt;

  pct_pkg::pct_result_t timer_results_q[$];
  int unsigned err_count;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned quiet_cycles;

  task automatic clear_timer_model();
    tmr_ctrl     = '0;
    tmr_prescale = '0;
    tmr_status   = '0;
    tmr_irq_en   = '0;
    tmr_compare  = '0;
    tmr_count    = '0;
    tmr_div_cnt  = '0;
  endtask

  task automatic restart_timer_model();
    tmr_count   = '0;
    tmr_div_cnt = '0;
  endtask

  // Applies one beat to the model and returns the result the block owes.
  task automatic apply_timer_beat(input logic [1:0] op, input logic [11:0] off,
                                  input logic [31:0] val,
                                  output pct_pkg::pct_result_t res);
    logic was_enabled;
    res.read_data = '0;
    case (op)
      pct_pkg::OP_READ: begin
        case (off)
          pct_pkg::OffCtrl:     res.read_data = tmr_ctrl;
          pct_pkg::OffPrescale: res.read_data = tmr_prescale;
          pct_pkg::OffStatus:   res.read_data = tmr_status;
          pct_pkg::OffIrqEn:    res.read_data = tmr_irq_en;
          pct_pkg::OffCompare:  res.read_data = tmr_compare;
          pct_pkg::OffCount:    res.read_data = tmr_count;
          default:              res.read_data = '0;
        endcase
      end
      pct_pkg::OP_WRITE: begin
        case (off)
          pct_pkg::OffCtrl: begin
            if ((val & pct_pkg::CtrlSoftReset) != '0) begin
              // Software reset wipes the bank and never stores its own bit.
              tmr_prescale = '0;
              tmr_status   = '0;
              tmr_irq_en   = '0;
              tmr_compare  = '0;
              restart_timer_model();
              tmr_ctrl = val & ~pct_pkg::CtrlSoftReset;
            end else begin
              was_enabled = tmr_ctrl[pct_pkg::CtrlEnableBit];
              tmr_ctrl = val;
              if (!was_enabled && val[pct_pkg::CtrlEnableBit]) restart_timer_model();
            end
          end
          pct_pkg::OffPrescale: begin
            tmr_prescale = val;
            if (tmr_ctrl[pct_pkg::CtrlEnableBit]) restart_timer_model();
          end
          pct_pkg::OffStatus: tmr_status = tmr_status & ~val;
          pct_pkg::OffIrqEn:  tmr_irq_en = val;
          pct_pkg::OffCompare: begin
            tmr_compare = val;
            if (tmr_ctrl[pct_pkg::CtrlEnableBit]) restart_timer_model();
          end
          default: ;
        endcase
      end
      pct_pkg::OP_TICK: begin
        if (tmr_ctrl[pct_pkg::CtrlEnableBit] && tmr_compare != '0) begin
          if (tmr_div_cnt >= tmr_prescale[pct_pkg::DivWidth-1:0]) begin
            tmr_div_cnt = '0;
            if (tmr_count >= tmr_compare) begin
              tmr_count = '0;
              tmr_status[pct_pkg::FlagOvfBit] = 1'b1;
            end else begin
              tmr_count = tmr_count + 32'd1;
            end
          end else begin
            tmr_div_cnt = tmr_div_cnt + 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.irq_level = tmr_status[pct_pkg::FlagOvfBit] & tmr_irq_en[pct_pkg::IrqEnOvfBit];
  endtask

  // --------------------------------------------------------------------------
  // Monitor. Both handshakes are sampled at the rising edge. An accepted input
  // beat is predicted first, so the queue is current before the output side
  // is checked in the same cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor_b
    pct_pkg::pct_result_t want;
    pct_pkg::pct_result_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        apply_timer_beat(opcode_i, reg_offset_i, write_value_i, want);
        timer_results_q.push_back(want);
      end
      if (out_valid_o && !out_stall_i) begin
        got.read_data = read_data_o;
        got.irq_level = irq_level_o;
        if (timer_results_q.size() == 0) begin
          $error("result beat with nothing outstanding: read_data %h irq_level %b",
                 got.read_data, got.irq_level);
          err_count++;
        end else begin
          want = timer_results_q.pop_front();
          if (got.read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, got.read_data);
            err_count++;
          end
          if (got.irq_level !== want.irq_level) begin
            $error("irq_level: expected %b, got %b", want.irq_level, got.irq_level);
            err_count++;
          end
        end
      end
    end
  end

  // The receiver stalls at random at the rate of the current phase.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < sink_stall_pct);
  end

  // A hang shows up as a long stretch with no beat accepted on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HangLimit) begin
      $display("[prescaled_compare_timer] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sender. Entered and left at a falling edge. Random gaps drop valid and
  // put junk on the payload, which the block must ignore.
  // --------------------------------------------------------------------------
  task automatic send_beat(input logic [1:0] op, input logic [11:0] off,
                           input logic [31:0] val);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i    <= 1'b0;
      opcode_i      <= 2'($urandom);
      reg_offset_i  <= 12'($urandom);
      write_value_i <= $urandom;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    reg_offset_i  <= off;
    write_value_i <= val;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    @(negedge clk_i);
  endtask

  // Register defaults after reset, read-back of stored control bits, and the
  // beats that must leave the bank alone: a write to the read-only count, a
  // write to an unaligned offset and the undecoded opcode.
  task automatic test_register_reset_and_access();
    send_beat(pct_pkg::OP_READ, pct_pkg::OffCtrl, 32'h0);
    send_beat(pct_pkg::OP_READ, pct_pkg::OffCount, 32'h0);
    send_beat(pct_pkg::OP_READ, 12'hFFF, 32'hFFFF_FFFF);
    send_beat(pct_pkg::OP_WRITE, pct_pkg::OffCtrl, 32'hFFFF_7FFE);
    send_beat(pct_pkg::OP_READ, pct_pkg::OffCtrl, 32'h0);
    send_beat(pct_pkg::OP_WRITE, pct_pkg::OffCount, 32'hFFFF_FFFF);
    send_beat(pct_pkg::OP_WRITE, 12'h011, 32'hFFFF_FFFF);
    send_beat(OpUnused, pct_pkg::OffCtrl, 32'hFFFF_FFFF);
  endtask

  // Divide by two with a compare of two: the sixth tick wraps the count,
  // raises the overflow flag and, with the enable set, the interrupt line.
  // Only the low prescaler bits set the divider. Writing ones clears status.
  task automatic test_prescaled_wrap_and_irq();
    send_beat(pct_pkg::OP_WRITE, pct_pkg::OffPrescale, 32'hFFFF_F001);
    send_beat(pct_pkg::OP_WRITE, pct_pkg::OffCompare, 32'd2);
    send_beat(pct_pkg::OP_WRITE, pct_pkg::OffIrqEn, 32'hFFFF_FFFF);
    send_beat(pct_pkg::OP_WRITE, pct_pkg::OffCtrl, 32'h0000_0001);
    repeat (6) send_beat(pct_pkg::OP_TICK, pct_pkg::OffCtrl, 32'h0);
    send_beat(pct_pkg::OP_READ, pct_pkg::OffCount, 32'h0);
    send_beat(pct_pkg::OP_READ, pct_pkg::OffStatus, 32'h0);
    send_beat(pct_pkg::OP_WRITE, pct_pkg::OffStatus, 32'hFFFF_FFFF);
  endtask

  // Software reset with every other bit set, then a tick that must do
  // nothing because the compare value is now zero.
  task automatic test_soft_reset_and_zero_compare();
    send_beat(pct_pkg::OP_WRITE, pct_pkg::OffCtrl, 32'hFFFF_FFFF);
    send_beat(pct_pkg::OP_READ, pct_pkg::OffCompare, 32'h0);
    send_beat(pct_pkg::OP_TICK, 12'h000, 32'h0);
    send_beat(pct_pkg::OP_READ, pct_pkg::OffCtrl, 32'h0);
  endtask

  // Mostly ticks with the timer running on small dividers and compares, so
  // that wraps are frequent; reads of every register, occasional restarts,
  // software resets and disables, and a few fully random beats as noise.
  task automatic test_random_traffic(input int unsigned idle_pct,
                                     input int unsigned stall_pct,
                                     input int unsigned num_beats);
    logic [1:0]  op;
    logic [11:0] off;
    logic [31:0] val;
    int unsigned pick;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    repeat (num_beats) begin
      pick = $urandom_range(99);
      val  = $urandom;
      if (pick < 55) begin
        op  = pct_pkg::OP_TICK;
        off = 12'($urandom);
      end else if (pick < 80) begin
        op = pct_pkg::OP_READ;
        case ($urandom_range(5))
          0:       off = pct_pkg::OffCtrl;
          1:       off = pct_pkg::OffPrescale;
          2:       off = pct_pkg::OffStatus;
          3:       off = pct_pkg::OffIrqEn;
          4:       off = pct_pkg::OffCompare;
          default: off = pct_pkg::OffCount;
        endcase
      end else if (pick < 95) begin
        op = pct_pkg::OP_WRITE;
        case ($urandom_range(5))
          0: begin
            off = pct_pkg::OffCtrl;
            val[pct_pkg::CtrlEnableBit] = ($urandom_range(3) != 0);
            val[15] = ($urandom_range(29) == 0);
          end
          1: begin
            off = pct_pkg::OffPrescale;
            // A divider drawn from its full range is rare; a large one slows the count.
            if ($urandom_range(15) == 0) val[pct_pkg::DivWidth-1:0] = 12'($urandom);
            else val[pct_pkg::DivWidth-1:0] = 12'($urandom_range(3));
          end
          2: off = pct_pkg::OffStatus;
          3: off = pct_pkg::OffIrqEn;
          4: begin
            off = pct_pkg::OffCompare;
            pick = $urandom_range(9);
            if (pick == 0) val = '0;
            else if (pick != 1) val = $urandom_range(1, 12);
          end
          default: off = pct_pkg::OffCount;
        endcase
      end else begin
        op  = 2'($urandom);
        off = 12'($urandom);
      end
      send_beat(op, off, val);
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    opcode_i       = pct_pkg::OP_READ;
    reg_offset_i   = pct_pkg::OffCtrl;
    write_value_i  = '0;
    out_stall_i    = 1'b0;
    err_count      = 0;
    quiet_cycles   = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    clear_timer_model();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_register_reset_and_access();
    test_prescaled_wrap_and_irq();
    test_soft_reset_and_zero_compare();
    test_random_traffic(0, 0, BeatsPerPhase);
    test_random_traffic(61, 0, BeatsPerPhase);
    test_random_traffic(0, 61, BeatsPerPhase);
    test_random_traffic(13, 13, BeatsPerPhase);

    // Let the pipeline drain; the watchdog catches a result that never comes.
    while (timer_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (err_count == 0) begin
      $display("[prescaled_compare_timer] OK");
    end else begin
      $display("[prescaled_compare_timer] ERROR");
    end
    $finish;
  end

endmodule
